@@ sv/bdpa_pkg.sv @@
// Shared types, microcode codes and BCD helper functions for the BCD
// date-time period advance unit. No dependencies.
`timescale 1ns / 1ps

package bdpa_pkg;

	localparam int PC_W   = 5;
	localparam int OP_W   = 4;
	localparam int COND_W = 4;

	// Datapath operations, one per control word.
	localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
	localparam logic [OP_W-1:0] OP_MUL       = 4'd1;
	localparam logic [OP_W-1:0] OP_MIN_LOAD  = 4'd2;
	localparam logic [OP_W-1:0] OP_MIN_DIV   = 4'd3;
	localparam logic [OP_W-1:0] OP_MIN_STORE = 4'd4;
	localparam logic [OP_W-1:0] OP_HR_LOAD   = 4'd5;
	localparam logic [OP_W-1:0] OP_HR_DIV    = 4'd6;
	localparam logic [OP_W-1:0] OP_HR_STORE  = 4'd7;
	localparam logic [OP_W-1:0] OP_DAY_LOAD  = 4'd8;
	localparam logic [OP_W-1:0] OP_DAY_STEP  = 4'd9;
	localparam logic [OP_W-1:0] OP_MON_LOAD  = 4'd10;
	localparam logic [OP_W-1:0] OP_MON_STEP  = 4'd11;
	localparam logic [OP_W-1:0] OP_DONE      = 4'd12;

	// Jump conditions.
	localparam logic [COND_W-1:0] COND_NONE     = 4'd0;
	localparam logic [COND_W-1:0] COND_UNIT_NE0 = 4'd1;
	localparam logic [COND_W-1:0] COND_UNIT_NE1 = 4'd2;
	localparam logic [COND_W-1:0] COND_UNIT_NE2 = 4'd3;
	localparam logic [COND_W-1:0] COND_UNIT_NE3 = 4'd4;
	localparam logic [COND_W-1:0] COND_CNT_ZERO = 4'd5;
	localparam logic [COND_W-1:0] COND_CNT_NE1  = 4'd6;
	localparam logic [COND_W-1:0] COND_ACC_GE60 = 4'd7;
	localparam logic [COND_W-1:0] COND_ACC_GE24 = 4'd8;

	localparam logic [2:0] UNIT_MINUTE = 3'd0;
	localparam logic [2:0] UNIT_HOUR   = 3'd1;
	localparam logic [2:0] UNIT_DAY    = 3'd2;
	localparam logic [2:0] UNIT_MONTH  = 3'd3;

	localparam logic [7:0] MINUTES_PER_HOUR = 8'd60;
	localparam logic [7:0] HOURS_PER_DAY    = 8'd24;
	localparam logic [7:0] FEB_LEAP_LEN     = 8'd29;
	localparam logic [7:0] FEB_LEN          = 8'd28;
	localparam logic [7:0] MONTHS_PER_YEAR  = 8'd12;
	localparam logic [7:0] LAST_YEAR        = 8'd99;
	localparam logic [7:0] MARCH_BCD        = 8'h03;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   target;
	} ctrl_t;

	typedef struct packed {
		logic [2:0] unit;
		logic       cnt_zero;
		logic       cnt_one;
		logic       acc_ge60;
		logic       acc_ge24;
	} stat_t;

	// Decode two nibbles as low + 10 * high; nibbles above nine pass through.
	function automatic logic [7:0] bcd_dec(input logic [7:0] b);
		logic [7:0] hi;
		hi = {4'd0, b[7:4]};
		return {4'd0, b[3:0]} + (hi << 3) + (hi << 1);
	endfunction

	// Encode a binary byte as (v mod 10) + 16 * (v / 10), kept to eight bits.
	// The quotient comes from a reciprocal multiply, exact for any byte.
	function automatic logic [7:0] bcd_enc(input logic [7:0] v);
		logic [15:0] prod;
		logic [4:0]  q;
		logic [7:0]  r;
		prod = {8'd0, v} * 16'd205;
		q    = prod[15:11];
		r    = v - ({3'd0, q} << 3) - ({3'd0, q} << 1);
		return {q[3:0], r[3:0]};
	endfunction

	function automatic logic [7:0] next_year(input logic [7:0] yb);
		logic [7:0] y;
		y = bcd_dec(yb) + 8'd1;
		if (y > LAST_YEAR) begin
			y = 8'd0;
		end
		return bcd_enc(y);
	endfunction

	// Length of months other than February.
	function automatic logic [7:0] month_len(input logic [3:0] m);
		case (m)
			4'd4, 4'd6, 4'd9, 4'd11: return 8'd30;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 8'd31;
			default: return 8'd0;
		endcase
	endfunction

endpackage

@@ sv/bdpa_seq.sv @@
// Microcode sequencer: program ROM, step counter and conditional jumps.
// Depends on bdpa_pkg.
`timescale 1ns / 1ps

module bdpa_seq import bdpa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  launch,
	input  stat_t stat,
	output ctrl_t ctrl,
	output logic  busy
);

	logic [PC_W-1:0] pc_q;
	logic            run_q;
	ctrl_t           word;
	logic            take;

	function automatic ctrl_t rom(input logic [PC_W-1:0] pc);
		case (pc)
			5'd0:  return '{OP_MUL,       COND_NONE,     5'd0};
			5'd1:  return '{OP_NOP,       COND_UNIT_NE0, 5'd5};
			5'd2:  return '{OP_MIN_LOAD,  COND_NONE,     5'd0};
			5'd3:  return '{OP_MIN_DIV,   COND_ACC_GE60, 5'd3};
			5'd4:  return '{OP_MIN_STORE, COND_NONE,     5'd0};
			5'd5:  return '{OP_NOP,       COND_UNIT_NE1, 5'd9};
			5'd6:  return '{OP_HR_LOAD,   COND_NONE,     5'd0};
			5'd7:  return '{OP_HR_DIV,    COND_ACC_GE24, 5'd7};
			5'd8:  return '{OP_HR_STORE,  COND_NONE,     5'd0};
			5'd9:  return '{OP_NOP,       COND_UNIT_NE2, 5'd13};
			5'd10: return '{OP_DAY_LOAD,  COND_NONE,     5'd0};
			5'd11: return '{OP_NOP,       COND_CNT_ZERO, 5'd13};
			5'd12: return '{OP_DAY_STEP,  COND_CNT_NE1,  5'd12};
			5'd13: return '{OP_NOP,       COND_UNIT_NE3, 5'd17};
			5'd14: return '{OP_MON_LOAD,  COND_NONE,     5'd0};
			5'd15: return '{OP_NOP,       COND_CNT_ZERO, 5'd17};
			5'd16: return '{OP_MON_STEP,  COND_CNT_NE1,  5'd16};
			5'd17: return '{OP_DONE,      COND_NONE,     5'd0};
			default: return '{OP_DONE,    COND_NONE,     5'd0};
		endcase
	endfunction

	assign word = rom(pc_q);

	always_comb begin
		case (word.cond)
			COND_UNIT_NE0: take = stat.unit != UNIT_MINUTE;
			COND_UNIT_NE1: take = stat.unit != UNIT_HOUR;
			COND_UNIT_NE2: take = stat.unit != UNIT_DAY;
			COND_UNIT_NE3: take = stat.unit != UNIT_MONTH;
			COND_CNT_ZERO: take = stat.cnt_zero;
			COND_CNT_NE1:  take = !stat.cnt_one;
			COND_ACC_GE60: take = stat.acc_ge60;
			COND_ACC_GE24: take = stat.acc_ge24;
			default:       take = 1'b0;
		endcase
	end

	always_comb begin
		ctrl = word;
		if (!run_q) begin
			ctrl = '{OP_NOP, COND_NONE, 5'd0};
		end
	end

	assign busy = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			run_q <= 1'b0;
		end else if (launch) begin
			pc_q  <= '0;
			run_q <= 1'b1;
		end else if (run_q) begin
			if (word.op == OP_DONE) begin
				run_q <= 1'b0;
			end
			pc_q <= take ? word.target : pc_q + 5'd1;
		end
	end

endmodule

@@ sv/bcd_datetime_period_advance_unit.sv @@
// Top level of the BCD date-time period advance unit: handshake, datapath
// registers and assertions. Depends on bdpa_pkg and bdpa_seq.
`timescale 1ns / 1ps

// How to use this block
// A beat is offered by raising start with the timestamp, unit_select,
// period_count and period_multiplier on their ports; it is taken at the
// rising edge where start is high and busy is low. busy then stays high
// while a small microcoded sequencer walks the work: one step forms the
// product, the minute and hour splits run by repeated subtraction, and
// days or months advance one calendar step per cycle.
// Minute carries are added to the hours, and the days carried out of the
// hours are then stepped one by one like requested days; unit codes 4
// to 7 leave the timestamp unchanged.
// The result beat appears on minute_out .. year_out with done high for
// exactly one cycle; busy is already low in that cycle, so a new beat may
// be accepted at the edge that ends it. The receiver cannot stall the
// block. Reset (arst_n low) returns the sequencer to idle at once and
// drops busy and done; no clearing pass is needed.

module bcd_datetime_period_advance_unit import bdpa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] minute_in,
	input  logic [7:0] hour_in,
	input  logic [7:0] day_in,
	input  logic [7:0] month_in,
	input  logic [7:0] year_in,
	input  logic [2:0] unit_select,
	input  logic [7:0] period_count,
	input  logic [7:0] period_multiplier,
	output logic       done,
	output logic [7:0] minute_out,
	output logic [7:0] hour_out,
	output logic [7:0] day_out,
	output logic [7:0] month_out,
	output logic [7:0] year_out
);

	// Timestamp being advanced, in BCD.
	logic [7:0] mi_q, ho_q, dy_q, mo_q, yr_q;
	// Operands latched at acceptance.
	logic [2:0] unit_q;
	logic [7:0] pcnt_q, pmul_q;
	// Work registers: units left to add, a binary accumulator, and a
	// counter that holds the carry and then the day or month steps left.
	logic [7:0] n_q, acc_q, cnt_q;
	logic       done_q;

	logic       launch;
	ctrl_t      ctrl;
	stat_t      stat;

	assign launch = start && !busy;

	assign stat.unit     = unit_q;
	assign stat.cnt_zero = cnt_q == 8'd0;
	assign stat.cnt_one  = cnt_q == 8'd1;
	assign stat.acc_ge60 = acc_q >= MINUTES_PER_HOUR;
	assign stat.acc_ge24 = acc_q >= HOURS_PER_DAY;

	bdpa_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.launch (launch),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// The multiplier treats zero as one; only the low byte of the product
	// is kept.
	logic [7:0]  mul_eff;
	logic [15:0] prod;
	assign mul_eff = (pmul_q == 8'd0) ? 8'd1 : pmul_q;
	assign prod    = pcnt_q * mul_eff;

	// One day step. February rolls into March with the year unchanged; the
	// leap test is on the decoded year. A month outside 1..12 freezes the
	// day, month and year.
	logic [7:0] day_d, day_mb, day_lim, day_m_next;
	logic [7:0] day_dy, day_mo, day_yr;
	always_comb begin
		day_d      = bcd_dec(dy_q) + 8'd1;
		day_mb     = bcd_dec(mo_q);
		day_lim    = month_len(day_mb[3:0]);
		day_m_next = day_mb + 8'd1;
		day_dy     = dy_q;
		day_mo     = mo_q;
		day_yr     = yr_q;
		if (day_mb == 8'd2) begin
			day_lim = (bcd_dec(yr_q) & 8'h03) == 8'd0 ? FEB_LEAP_LEN : FEB_LEN;
			if (day_d > day_lim) begin
				day_d  = 8'd1;
				day_mo = MARCH_BCD;
			end
			day_dy = bcd_enc(day_d);
		end else if (day_mb >= 8'd1 && day_mb <= MONTHS_PER_YEAR) begin
			if (day_d > day_lim) begin
				day_d = 8'd1;
				if (day_m_next > MONTHS_PER_YEAR) begin
					day_m_next = 8'd1;
					day_yr     = next_year(yr_q);
				end
				day_mo = bcd_enc(day_m_next);
			end
			day_dy = bcd_enc(day_d);
		end
	end

	// One month step; the month range is not checked on the way in.
	logic [7:0] mon_m, mon_mo, mon_yr;
	always_comb begin
		mon_m  = bcd_dec(mo_q) + 8'd1;
		mon_yr = yr_q;
		if (mon_m > MONTHS_PER_YEAR) begin
			mon_m  = 8'd1;
			mon_yr = next_year(yr_q);
		end
		mon_mo = bcd_enc(mon_m);
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			mi_q   <= minute_in;
			ho_q   <= hour_in;
			dy_q   <= day_in;
			mo_q   <= month_in;
			yr_q   <= year_in;
			unit_q <= unit_select;
			pcnt_q <= period_count;
			pmul_q <= period_multiplier;
		end else begin
			case (ctrl.op)
				OP_MUL: begin
					n_q   <= prod[7:0];
					cnt_q <= 8'd0;
				end
				OP_MIN_LOAD: begin
					acc_q <= bcd_dec(mi_q) + n_q;
				end
				OP_MIN_DIV: begin
					if (stat.acc_ge60) begin
						acc_q <= acc_q - MINUTES_PER_HOUR;
						cnt_q <= cnt_q + 8'd1;
					end
				end
				OP_MIN_STORE: begin
					mi_q <= bcd_enc(acc_q);
					if (!stat.cnt_zero) begin
						unit_q <= UNIT_HOUR;
						n_q    <= 8'd0;
					end
				end
				OP_HR_LOAD: begin
					acc_q <= bcd_dec(ho_q) + cnt_q + n_q;
					cnt_q <= 8'd0;
				end
				OP_HR_DIV: begin
					if (stat.acc_ge24) begin
						acc_q <= acc_q - HOURS_PER_DAY;
						cnt_q <= cnt_q + 8'd1;
					end
				end
				OP_HR_STORE: begin
					ho_q <= bcd_enc(acc_q);
					if (!stat.cnt_zero) begin
						unit_q <= UNIT_DAY;
						n_q    <= 8'd0;
					end
				end
				OP_DAY_LOAD: begin
					cnt_q <= cnt_q + n_q;
				end
				OP_DAY_STEP: begin
					dy_q  <= day_dy;
					mo_q  <= day_mo;
					yr_q  <= day_yr;
					cnt_q <= cnt_q - 8'd1;
				end
				OP_MON_LOAD: begin
					cnt_q <= n_q;
				end
				OP_MON_STEP: begin
					mo_q  <= mon_mo;
					yr_q  <= mon_yr;
					cnt_q <= cnt_q - 8'd1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.op == OP_DONE;
		end
	end

	assign done       = done_q;
	assign minute_out = mi_q;
	assign hour_out   = ho_q;
	assign day_out    = dy_q;
	assign month_out  = mo_q;
	assign year_out   = yr_q;

	// The result beat comes after the sequencer has gone idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while the sequencer is still busy");

	// An accepted beat always starts the sequencer.
	a_launch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		launch |=> busy)
		else $error("accepted beat did not start the sequencer");

	// The day and month loops are never entered with no steps left.
	a_loop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_DAY_STEP || ctrl.op == OP_MON_STEP) |-> !stat.cnt_zero)
		else $error("calendar step taken with an empty step count");

	// The minute and hour remainders are in range when they are stored.
	a_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_MIN_STORE || ctrl.op == OP_HR_STORE) |->
		(!stat.acc_ge60 && (ctrl.op == OP_MIN_STORE || !stat.acc_ge24)))
		else $error("division loop left a remainder out of range");

endmodule
